FILE: hw/rtl/sha1_pkg.sv
`timescale 1ns / 1ps

package sha1_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned FillW      = $clog2(BlockBytes);
  localparam int unsigned IdxW       = $clog2(NumWords);

  // round counter runs 0..79, then at 80 the working words fold into the chain
  localparam logic [6:0] RoundsLast = 7'd79;
  localparam logic [6:0] RoundFold  = 7'd80;
  localparam logic [6:0] Phase1     = 7'd20;
  localparam logic [6:0] Phase2     = 7'd40;
  localparam logic [6:0] Phase3     = 7'd60;

  localparam logic [FillW-1:0] FillLast  = FillW'(BlockBytes - 1);
  localparam logic [FillW-1:0] FillLenAt = FillW'(56);
  localparam logic [7:0]       PadByte   = 8'h80;
  localparam logic [3:0]       LenBytes  = 4'd8;
  localparam logic [IdxW-1:0]  IdxLast   = IdxW'(NumWords - 1);

  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLK_WAIT,
    ST_PAD,
    ST_PAD_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       byte_we;
    logic [7:0] data_byte;
    logic       start;
    logic       chain_init;
  } core_ctl_t;

  function automatic logic [31:0] init_word(logic [IdxW-1:0] idx);
    logic [31:0] w;
    unique case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hEFCDAB89;
      3'd2:    w = 32'h98BADCFE;
      3'd3:    w = 32'h10325476;
      3'd4:    w = 32'hC3D2E1F0;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] round_k(logic [6:0] t);
    logic [31:0] k;
    priority if (t < Phase1) k = 32'h5A827999;
    else if (t < Phase2)     k = 32'h6ED9EBA1;
    else if (t < Phase3)     k = 32'h8F1BBCDC;
    else                     k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(logic [6:0] t, logic [31:0] b, logic [31:0] c,
                                          logic [31:0] d);
    logic [31:0] f;
    priority if (t < Phase1) f = d ^ (b & (c ^ d));
    else if (t < Phase2)     f = b ^ c ^ d;
    else if (t < Phase3)     f = (b & c) | (d & (b | c));
    else                     f = b ^ c ^ d;
    return f;
  endfunction

endpackage

FILE: hw/rtl/sha1_core.sv
`timescale 1ns / 1ps

module sha1_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1_pkg::core_ctl_t   ctl_i,
  output logic                  busy_o,
  output logic [31:0]           chain_o [sha1_pkg::NumWords]
);

  // block buffer doubles as the message schedule window: win[0] is w[t]
  logic [31:0] win_q [sha1_pkg::BlockWords];
  logic [31:0] win_d [sha1_pkg::BlockWords];
  logic [31:0] chain_q [sha1_pkg::NumWords];
  logic [31:0] chain_d [sha1_pkg::NumWords];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic [6:0]  rnd_q, rnd_d;
  logic        busy_q, busy_d;
  logic [31:0] w_next;
  logic [31:0] tmp;

  assign w_next = {win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]} << 1 |
                  {31'b0, win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};
  assign tmp = sha1_pkg::round_f(rnd_q, b_q, c_q, d_q) + sha1_pkg::round_k(rnd_q) +
               {a_q[26:0], a_q[31:27]} + e_q + win_q[0];

  always_comb begin
    win_d   = win_q;
    chain_d = chain_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    e_d     = e_q;
    rnd_d   = rnd_q;
    busy_d  = busy_q;

    if (busy_q) begin
      if (rnd_q == sha1_pkg::RoundFold) begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
        busy_d     = 1'b0;
      end else begin
        for (int i = 0; i < sha1_pkg::BlockWords - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[sha1_pkg::BlockWords-1] = w_next;
        a_d   = tmp;
        b_d   = a_q;
        c_d   = {b_q[1:0], b_q[31:2]};
        d_d   = c_q;
        e_d   = d_q;
        rnd_d = rnd_q + 7'd1;
      end
    end else begin
      if (ctl_i.byte_we) begin
        for (int i = 0; i < sha1_pkg::BlockWords - 1; i++) begin
          win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
        end
        win_d[sha1_pkg::BlockWords-1] = {win_q[sha1_pkg::BlockWords-1][23:0],
                                         ctl_i.data_byte};
      end
      if (ctl_i.start) begin
        a_d    = chain_q[0];
        b_d    = chain_q[1];
        c_d    = chain_q[2];
        d_d    = chain_q[3];
        e_d    = chain_q[4];
        rnd_d  = 7'd0;
        busy_d = 1'b1;
      end
      if (ctl_i.chain_init) begin
        for (int i = 0; i < sha1_pkg::NumWords; i++) begin
          chain_d[i] = sha1_pkg::init_word(sha1_pkg::IdxW'(i));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 7'd0;
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        chain_q[i] <= sha1_pkg::init_word(sha1_pkg::IdxW'(i));
      end
    end else begin
      busy_q  <= busy_d;
      rnd_q   <= rnd_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

  assign busy_o  = busy_q;
  assign chain_o = chain_q;

endmodule

FILE: hw/rtl/sha1_stream_hasher_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | command_i, data_byte_i
// out     | output    | out_valid_o/out_ready_i | digest_word_o, word_index_o, last_word_o
//
// An absorb beat writes one byte; the beat that fills a 64-byte block starts the compression
// (one round per cycle through one shared round unit, plus fold). A finish beat feeds 9..72
// pad bytes, one per cycle while no compression runs, runs one or two compressions, then
// offers five digest beats. in_ready_o is low until the last digest beat is taken.
// Reset restores the initial chaining values and clears the byte counters.
// Output stalls hold the digest beat; the block waits without losing state.

module sha1_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha1_pkg::state_e             state_q, state_d;
  logic [sha1_pkg::FillW-1:0]   fill_q, fill_d;
  logic [31:0]                  msg_q, msg_d;
  logic                         first_q, first_d;
  logic [3:0]                   len_cnt_q, len_cnt_d;
  logic [sha1_pkg::IdxW-1:0]    out_idx_q, out_idx_d;
  sha1_pkg::core_ctl_t          ctl;
  logic                         busy;
  logic [31:0]                  chain [sha1_pkg::NumWords];
  logic [63:0]                  bit_len;
  logic [7:0]                   len_byte;

  sha1_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .busy_o  (busy),
    .chain_o (chain)
  );

  assign bit_len  = {29'b0, msg_q, 3'b000};
  // big-endian: first length byte is the top byte
  assign len_byte = 8'(bit_len >> {~len_cnt_q[2:0], 3'b000});

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    msg_d     = msg_q;
    first_d   = first_q;
    len_cnt_d = len_cnt_q;
    out_idx_d = out_idx_q;
    ctl       = '0;

    unique case (state_q)
      sha1_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i == sha1_pkg::CmdAbsorb) begin
            ctl.byte_we   = 1'b1;
            ctl.data_byte = data_byte_i;
            msg_d         = msg_q + 32'd1;
            fill_d        = fill_q + 1'b1;
            if (fill_q == sha1_pkg::FillLast) begin
              ctl.start = 1'b1;
              state_d   = sha1_pkg::ST_BLK_WAIT;
            end
          end else begin
            first_d   = 1'b1;
            len_cnt_d = 4'd0;
            state_d   = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_BLK_WAIT: begin
        if (!busy) begin
          state_d = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_PAD: begin
        ctl.byte_we = 1'b1;
        fill_d      = fill_q + 1'b1;
        priority if (first_q) begin
          ctl.data_byte = sha1_pkg::PadByte;
          first_d       = 1'b0;
        end else if (len_cnt_q != 4'd0 || fill_q == sha1_pkg::FillLenAt) begin
          ctl.data_byte = len_byte;
          len_cnt_d     = len_cnt_q + 4'd1;
        end else begin
          ctl.data_byte = 8'h00;
        end
        if (fill_q == sha1_pkg::FillLast) begin
          ctl.start = 1'b1;
          state_d   = sha1_pkg::ST_PAD_WAIT;
        end
      end
      sha1_pkg::ST_PAD_WAIT: begin
        if (!busy) begin
          if (len_cnt_q == sha1_pkg::LenBytes) begin
            out_idx_d = '0;
            state_d   = sha1_pkg::ST_OUT;
          end else begin
            state_d = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_ready_i) begin
          if (out_idx_q == sha1_pkg::IdxLast) begin
            ctl.chain_init = 1'b1;
            fill_d         = '0;
            msg_d          = 32'd0;
            state_d        = sha1_pkg::ST_IDLE;
          end else begin
            out_idx_d = out_idx_q + 1'b1;
          end
        end
      end
      default: state_d = sha1_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha1_pkg::ST_IDLE;
      fill_q    <= '0;
      msg_q     <= 32'd0;
      first_q   <= 1'b0;
      len_cnt_q <= 4'd0;
      out_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      msg_q     <= msg_d;
      first_q   <= first_d;
      len_cnt_q <= len_cnt_d;
      out_idx_q <= out_idx_d;
    end
  end

  assign in_ready_o    = (state_q == sha1_pkg::ST_IDLE);
  assign out_valid_o   = (state_q == sha1_pkg::ST_OUT);
  assign digest_word_o = chain[out_idx_q];
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == sha1_pkg::IdxLast);

endmodule

FILE: sim/sha1_stream_hasher_top_tb.sv
`timescale 1ns / 1ps

module sha1_stream_hasher_top_tb;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } hash_beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        command_i   = sha1_pkg::CmdAbsorb;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha1_stream_hasher_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  hash_beat_t   pending_q[$];
  digest_beat_t digest_q[$];
  int           total_beats;
  int           beats_sent;
  int           beats_taken;
  int           words_seen;
  int           mismatches;

  // shadow of the hasher
  logic [31:0] hash_chain [5];
  logic [7:0]  blk_bytes  [64];
  logic [5:0]  block_fill;
  logic [31:0] msg_len;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic void restart_hash();
    hash_chain[0] = 32'h67452301;
    hash_chain[1] = 32'hEFCDAB89;
    hash_chain[2] = 32'h98BADCFE;
    hash_chain[3] = 32'h10325476;
    hash_chain[4] = 32'hC3D2E1F0;
    block_fill    = '0;
    msg_len       = '0;
  endfunction

  function automatic void sha_rounds();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, mix;
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        mix = w[(t+13)&15] ^ w[(t+8)&15] ^ w[(t+2)&15] ^ w[t&15];
        w[t&15] = {mix[30:0], mix[31]};
      end
      if (t < 20)      f = (d ^ (b & (c ^ d))) + 32'h5A827999;
      else if (t < 40) f = (b ^ c ^ d) + 32'h6ED9EBA1;
      else if (t < 60) f = ((b & c) | (d & (b | c))) + 32'h8F1BBCDC;
      else             f = (b ^ c ^ d) + 32'hCA62C1D6;
      mix = f + {a[26:0], a[31:27]} + e + w[t&15];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = mix;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  function automatic void push_block_byte(input logic [7:0] v);
    blk_bytes[block_fill] = v;
    if (block_fill == 6'd63) begin
      sha_rounds();
      block_fill = '0;
    end else begin
      block_fill++;
    end
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    msg_len++;
    push_block_byte(v);
  endfunction

  // pad, append bit length, queue the five digest words, restart
  function automatic void close_message();
    logic [63:0]  bit_len;
    digest_beat_t dw;
    bit_len = {32'h0, msg_len} << 3;
    push_block_byte(8'h80);
    while (block_fill != 6'd56) push_block_byte(8'h00);
    for (int i = 7; i >= 0; i--) push_block_byte(bit_len[i*8 +: 8]);
    for (int n = 0; n < 5; n++) begin
      dw.word = hash_chain[n];
      dw.idx  = 3'(n);
      dw.last = (n == 4);
      digest_q.push_back(dw);
    end
    restart_hash();
  endfunction

  function automatic bit take_gap(input bit calm);
    return !calm && ($urandom_range(99) < 22);
  endfunction

  task automatic add_beat(input logic cmd, input logic [7:0] data);
    hash_beat_t hb;
    hb.cmd  = cmd;
    hb.data = data;
    pending_q.push_back(hb);
  endtask

  // random bytes then a finish; the finish carries a random, ignored byte
  task automatic add_message(input int len);
    for (int i = 0; i < len; i++) add_beat(sha1_pkg::CmdAbsorb, 8'($urandom_range(255)));
    add_beat(sha1_pkg::CmdFinish, 8'($urandom_range(255)));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    hash_beat_t nxt;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      command_i   <= sha1_pkg::CmdAbsorb;
      data_byte_i <= 8'h00;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (command_i == sha1_pkg::CmdFinish) close_message();
        else absorb_byte(data_byte_i);
        beats_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() > 0 && !take_gap(beats_sent >= 150 && beats_sent < 230)) begin
          nxt = pending_q.pop_front();
          beats_sent++;
          in_valid_i  <= 1'b1;
          command_i   <= nxt.cmd;
          data_byte_i <= nxt.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_out
    digest_beat_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        words_seen++;
        if (digest_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected digest beat word=%h idx=%0d last=%b",
                                  digest_word_o, word_index_o, last_word_o));
        end else begin
          want = digest_q.pop_front();
          if (digest_word_o !== want.word)
            flag_mismatch($sformatf("digest_word %h, want %h (idx %0d)",
                                    digest_word_o, want.word, want.idx));
          if (word_index_o !== want.idx)
            flag_mismatch($sformatf("word_index %0d, want %0d", word_index_o, want.idx));
          if (last_word_o !== want.last)
            flag_mismatch($sformatf("last_word %b, want %b (idx %0d)",
                                    last_word_o, want.last, want.idx));
        end
      end
      out_ready_i <= !take_gap(words_seen >= 40 && words_seen < 80);
    end
  end

  initial begin : run_hasher
    int rand_beats;
    int len;
    int edge_lens [10];
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    restart_hash();

    // empty message, data byte on a finish is ignored
    add_beat(sha1_pkg::CmdFinish, 8'hFF);
    add_beat(sha1_pkg::CmdAbsorb, 8'h61);
    add_beat(sha1_pkg::CmdAbsorb, 8'h62);
    add_beat(sha1_pkg::CmdAbsorb, 8'h63);
    add_beat(sha1_pkg::CmdFinish, 8'h00);
    add_beat(sha1_pkg::CmdAbsorb, 8'h00);
    add_beat(sha1_pkg::CmdFinish, 8'hA5);
    add_beat(sha1_pkg::CmdAbsorb, 8'hFF);
    add_beat(sha1_pkg::CmdFinish, 8'h5A);
    add_beat(sha1_pkg::CmdAbsorb, 8'h55);
    add_beat(sha1_pkg::CmdAbsorb, 8'hAA);
    add_beat(sha1_pkg::CmdFinish, 8'h80);
    // back-to-back empty messages
    add_beat(sha1_pkg::CmdFinish, 8'h00);
    add_beat(sha1_pkg::CmdFinish, 8'h01);

    // lengths that force one or two padding blocks
    rand_beats = pending_q.size();
    add_message(55);
    add_message(56);
    add_message(64);
    while (pending_q.size() - rand_beats < 330) begin
      if ($urandom_range(99) < 10) len = edge_lens[$urandom_range(9)];
      else len = $urandom_range(12);
      add_message(len);
    end
    total_beats = pending_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken < total_beats || digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sha1_stream_hasher_top_tb: PASS");
    end else begin
      $display("sha1_stream_hasher_top_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("sha1_stream_hasher_top_tb: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_core.sv
hw/rtl/sha1_stream_hasher_top.sv
sim/sha1_stream_hasher_top_tb.sv
